// File: hdl/bresenham_line_stepper_assert.svh
// Assertion macros for the line stepper.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define BLS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bls_pkg.sv
// Package for the line stepper: widths, command codes, payload and queue types.
// No dependencies; imported by every module of the block.
`default_nettype none

package bls_pkg;

   // Coordinate width and the widths that follow from it
   localparam int CoordBits  = 12;
   localparam int NegBits    = CoordBits + 1;  // negated |dy|, signed
   localparam int ErrBits    = CoordBits + 2;  // error term, signed
   localparam int E2Bits     = CoordBits + 3;  // doubled error term
   localparam int ColorBits  = 32;

   // Queue between front and back
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = $clog2(QueueDepth);
   localparam int QCountBits = $clog2(QueueDepth + 1);

   // Command codes
   localparam logic CmdStart = 1'b0;
   localparam logic CmdStep  = 1'b1;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic        [CoordBits-1:0] delta_type;
   typedef logic signed [NegBits-1:0]   neg_delta_type;
   typedef logic signed [ErrBits-1:0]   err_type;
   typedef logic        [ColorBits-1:0] color_type;

   typedef struct packed {
      logic      cmd;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type color_in;
   } req_payload_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type color_out;
      logic      last;
   } rsp_payload_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      logic          cmd;
      coord_type     start_x;
      coord_type     start_y;
      coord_type     end_x;
      coord_type     end_y;
      delta_type     abs_dx;
      neg_delta_type neg_abs_dy;
      logic          dir_x_neg;
      logic          dir_y_neg;
      err_type       error_term;
      color_type     color;
   } line_item_type;

   // Status of the back end, watched by the top level checks
   typedef struct packed {
      logic active;
      logic pop;
      logic head_step;
   } back_status_type;

endpackage

`default_nettype wire

// File: hdl/bls_front.sv
// Front end: takes request items and works out deltas, directions and the
// initial error term for start items. Depends on bls_pkg.
`default_nettype none

module bls_front (
   input  wire                      req_valid,
   output logic                     req_ready,
   input  bls_pkg::req_payload_type req_payload,
   input  wire                      q_full,
   output logic                     q_push,
   output bls_pkg::line_item_type   q_data
);
   import bls_pkg::*;

   logic signed [NegBits-1:0] ddx;
   logic signed [NegBits-1:0] ddy;
   logic signed [NegBits-1:0] abs_dx_full;
   delta_type                 abs_dx;
   neg_delta_type             neg_abs_dy;

   // Handshake: take an item whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Deltas and their magnitudes
   always_comb begin
      ddx         = NegBits'(req_payload.x_end) - NegBits'(req_payload.x_start);
      ddy         = NegBits'(req_payload.y_end) - NegBits'(req_payload.y_start);
      abs_dx_full = (ddx < 0) ? -ddx : ddx;
      abs_dx      = abs_dx_full[CoordBits-1:0];
      neg_abs_dy  = (ddy < 0) ? ddy : -ddy;
   end

   // Classified item
   always_comb begin
      q_data.cmd        = req_payload.cmd;
      q_data.start_x    = req_payload.x_start;
      q_data.start_y    = req_payload.y_start;
      q_data.end_x      = req_payload.x_end;
      q_data.end_y      = req_payload.y_end;
      q_data.abs_dx     = abs_dx;
      q_data.neg_abs_dy = neg_abs_dy;
      q_data.dir_x_neg  = !(req_payload.x_start < req_payload.x_end);
      q_data.dir_y_neg  = !(req_payload.y_start < req_payload.y_end);
      q_data.error_term = $signed(ErrBits'(abs_dx)) + ErrBits'(neg_abs_dy);
      q_data.color      = req_payload.color_in;
   end

endmodule

`default_nettype wire

// File: hdl/bls_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on bls_pkg.
`default_nettype none

module bls_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  bls_pkg::line_item_type push_data,
   input  wire                    pop,
   output logic                   full,
   output logic                   head_valid,
   output bls_pkg::line_item_type head_data
);
   import bls_pkg::*;

   line_item_type          entry_ff [QueueDepth];
   logic [QPtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCountBits-1:0]  count_ff,  count_in;

   assign full       = (count_ff == QCountBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/bls_back.sv
// Back end: holds the line state, steps the Bresenham error term and
// registers a pixel per start item or active step item. Depends on bls_pkg.
`default_nettype none

module bls_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      head_valid,
   input  bls_pkg::line_item_type   head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output bls_pkg::rsp_payload_type rsp_payload,
   output bls_pkg::back_status_type status
);
   import bls_pkg::*;

   // Line state
   coord_type     cur_x_ff,      cur_x_in;
   coord_type     cur_y_ff,      cur_y_in;
   coord_type     end_x_ff,      end_x_in;
   coord_type     end_y_ff,      end_y_in;
   delta_type     abs_dx_ff,     abs_dx_in;
   neg_delta_type neg_abs_dy_ff, neg_abs_dy_in;
   logic          dir_x_neg_ff,  dir_x_neg_in;
   logic          dir_y_neg_ff,  dir_y_neg_in;
   err_type       error_ff,      error_in;
   color_type     color_ff,      color_in;
   logic          active_ff,     active_in;

   // Output register
   logic            rsp_valid_ff,   rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                     out_free;
   logic                     is_start;
   logic                     emit;
   logic signed [E2Bits-1:0] e2;
   logic                     step_x;
   logic                     step_y;
   err_type                  err_add_x;
   err_type                  err_add_y;
   coord_type                delta_x;
   coord_type                delta_y;
   logic                     at_end;

   // Pop when the output register is free or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = head_valid && out_free;
   assign is_start = (head_data.cmd == CmdStart);
   assign emit     = pop && (is_start || active_ff);

   // Step decision from the doubled error term
   always_comb begin
      e2        = $signed({error_ff, 1'b0});
      step_x    = (e2 >= E2Bits'(neg_abs_dy_ff));
      step_y    = (e2 <= $signed(E2Bits'(abs_dx_ff)));
      err_add_x = step_x ? ErrBits'(neg_abs_dy_ff) : '0;
      err_add_y = step_y ? $signed(ErrBits'(abs_dx_ff)) : '0;
      delta_x   = dir_x_neg_ff ? '1 : CoordBits'(1);
      delta_y   = dir_y_neg_ff ? '1 : CoordBits'(1);
   end

   // Next line state
   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      abs_dx_in     = abs_dx_ff;
      neg_abs_dy_in = neg_abs_dy_ff;
      dir_x_neg_in  = dir_x_neg_ff;
      dir_y_neg_in  = dir_y_neg_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      if (pop && is_start) begin
         cur_x_in      = head_data.start_x;
         cur_y_in      = head_data.start_y;
         end_x_in      = head_data.end_x;
         end_y_in      = head_data.end_y;
         abs_dx_in     = head_data.abs_dx;
         neg_abs_dy_in = head_data.neg_abs_dy;
         dir_x_neg_in  = head_data.dir_x_neg;
         dir_y_neg_in  = head_data.dir_y_neg;
         error_in      = head_data.error_term;
         color_in      = head_data.color;
      end else if (pop && active_ff) begin
         cur_x_in = step_x ? cur_x_ff + delta_x : cur_x_ff;
         cur_y_in = step_y ? cur_y_ff + delta_y : cur_y_ff;
         error_in = error_ff + err_add_x + err_add_y;
      end
      at_end    = (cur_x_in == end_x_in) && (cur_y_in == end_y_in);
      active_in = emit ? !at_end : active_ff;
   end

   // Next output register contents
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.pixel_x   = cur_x_in;
         rsp_payload_in.pixel_y   = cur_y_in;
         rsp_payload_in.color_out = color_in;
         rsp_payload_in.last      = at_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath state
   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      end_x_ff       <= end_x_in;
      end_y_ff       <= end_y_in;
      abs_dx_ff      <= abs_dx_in;
      neg_abs_dy_ff  <= neg_abs_dy_in;
      dir_x_neg_ff   <= dir_x_neg_in;
      dir_y_neg_ff   <= dir_y_neg_in;
      error_ff       <= error_in;
      color_ff       <= color_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      status.active    = active_ff;
      status.pop       = pop;
      status.head_step = (head_data.cmd == CmdStep);
   end

endmodule

`default_nettype wire

// File: hdl/bresenham_line_stepper.sv
// Bresenham line stepper, top level.
// Depends on bls_pkg, bls_front, bls_queue, bls_back and the assert header.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes commands. A start item
//   (cmd = start) loads both endpoints and the color and yields the start
//   pixel. Each step item yields the next pixel; the end point carries last.
//   A step while no line is active yields nothing. A start abandons any line.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) delivers pixels.
//   Path: an accepted item is written into the two-entry queue; from its head
//   the back end steps it into the output register, which drives rsp.
//   Throughput: one item per clock while the receiver takes pixels; the
//   output register takes a new pixel in the cycle the old one is taken.
//   Reset: synchronous, active high; the queue empties and no line is active.
//   Receiver stall: the pixel holds in the output register, the back end
//   stops popping, and req_ready drops once the queue is full.
`default_nettype none

module bresenham_line_stepper (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  bls_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output bls_pkg::rsp_payload_type rsp_payload
);
   import bls_pkg::*;

   logic            q_full;
   logic            q_push;
   line_item_type   q_in;
   logic            q_head_valid;
   line_item_type   q_head;
   logic            q_pop;
   back_status_type back_status;

   bls_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   bls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   bls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .status      (back_status)
   );

   // Checks
`include "bresenham_line_stepper_assert.svh"

   `BLS_ASSERT_IMPL(a_pop_needs_item, back_status.pop, q_head_valid,
      "back end popped an empty queue")
   `BLS_ASSERT_IMPL(a_last_ends_line, rsp_valid && rsp_payload.last, !back_status.active,
      "line still active while its last pixel is pending")
   `BLS_ASSERT_NEXT(a_idle_step_silent,
      back_status.pop && back_status.head_step && !back_status.active, !rsp_valid,
      "step while idle produced a pixel")

endmodule

`default_nettype wire

// File: tb/line_pixel_checker.sv
// Pixel checker for the line stepper: watches both channels, predicts each pixel
// and compares it with what the block delivers. Depends on bls_pkg.
`timescale 1ns / 1ps

module line_pixel_checker (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_ready,
   input  bls_pkg::req_payload_type req_payload,
   input  wire                      rsp_valid,
   input  wire                      rsp_ready,
   input  bls_pkg::rsp_payload_type rsp_payload,
   output int                       fail_count,
   output int                       pixels_pending,
   output int                       pixels_checked,
   output int                       lines_started,
   output int                       line_ends
);
   import bls_pkg::*;

   rsp_payload_type expected_pixels[$];

   // Predicted line state
   coord_type     pen_x, pen_y;
   coord_type     goal_x, goal_y;
   delta_type     run_x;      // |dx|
   neg_delta_type rise_neg;   // -|dy|
   logic          x_back, y_back;
   err_type       err_acc;
   color_type     ink;
   logic          drawing;

   int mismatches;
   int pixels_seen;
   int starts_seen;
   int ends_seen;

   // Work out the pixel an accepted item yields, if any, and queue it
   task automatic advance_line(input req_payload_type item);
      int xs, ys, xe, ye, ddx, ddy, e2;
      rsp_payload_type px;
      if (item.cmd == CmdStep && !drawing)
         return;
      if (item.cmd == CmdStart) begin
         xs = item.x_start;
         ys = item.y_start;
         xe = item.x_end;
         ye = item.y_end;
         ddx = xe - xs;
         ddy = ye - ys;
         pen_x = item.x_start;
         pen_y = item.y_start;
         goal_x = item.x_end;
         goal_y = item.y_end;
         run_x = delta_type'(ddx < 0 ? -ddx : ddx);
         rise_neg = neg_delta_type'(ddy < 0 ? ddy : -ddy);
         x_back = !(xs < xe);
         y_back = !(ys < ye);
         err_acc = err_type'(int'(run_x) + int'(rise_neg));
         ink = item.color_in;
         starts_seen++;
      end else begin
         // Both axis moves are decided from the error before either update
         e2 = 2 * int'(err_acc);
         if (e2 >= int'(rise_neg)) begin
            err_acc = err_type'(int'(err_acc) + int'(rise_neg));
            pen_x = x_back ? coord_type'(pen_x - 1) : coord_type'(pen_x + 1);
         end
         if (e2 <= int'(run_x)) begin
            err_acc = err_type'(int'(err_acc) + int'(run_x));
            pen_y = y_back ? coord_type'(pen_y - 1) : coord_type'(pen_y + 1);
         end
      end
      px.pixel_x = pen_x;
      px.pixel_y = pen_y;
      px.color_out = ink;
      px.last = (pen_x == goal_x) && (pen_y == goal_y);
      drawing = !px.last;
      expected_pixels.push_back(px);
   endtask

   task automatic flag_field(input string field, input longint want, input longint got);
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endtask

   // Compare a delivered pixel with the oldest prediction
   task automatic check_pixel(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         $error("pixel with none expected: x=%0d y=%0d", got.pixel_x, got.pixel_y);
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
         flag_field("pixel_x", want.pixel_x, got.pixel_x);
      if (got.pixel_y !== want.pixel_y)
         flag_field("pixel_y", want.pixel_y, got.pixel_y);
      if (got.color_out !== want.color_out)
         flag_field("color_out", want.color_out, got.color_out);
      if (got.last !== want.last)
         flag_field("last", want.last, got.last);
      pixels_seen++;
      if (want.last)
         ends_seen++;
   endtask

   // Sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         pen_x = '0;
         pen_y = '0;
         goal_x = '0;
         goal_y = '0;
         run_x = '0;
         rise_neg = '0;
         x_back = 1'b0;
         y_back = 1'b0;
         err_acc = '0;
         ink = '0;
         drawing = 1'b0;
      end else begin
         if (req_valid && req_ready)
            advance_line(req_payload);
         if (rsp_valid && rsp_ready)
            check_pixel(rsp_payload);
      end
      fail_count <= mismatches;
      pixels_pending <= expected_pixels.size();
      pixels_checked <= pixels_seen;
      lines_started <= starts_seen;
      line_ends <= ends_seen;
   end

   initial begin
      mismatches = 0;
      pixels_seen = 0;
      starts_seen = 0;
      ends_seen = 0;
   end

endmodule

// File: tb/bresenham_line_stepper_tb.sv
// Testbench top for the line stepper: clock, reset, item stimulus and verdict.
// Depends on bls_pkg, bresenham_line_stepper and line_pixel_checker.
`timescale 1ns / 1ps

module bresenham_line_stepper_tb;
   import bls_pkg::*;

   localparam int ItemTarget = 1900;
   localparam int LongHold   = 300;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int fail_count, pixels_pending, pixels_checked, lines_started, line_ends;

   // Idle odds in percent for each side, and long receiver holds asked / served
   int send_idle_pct = 17;
   int recv_idle_pct = 88;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;

   // Items sent that yield a pixel
   int pixel_items = 0;

   bresenham_line_stepper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   line_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending),
      .pixels_checked (pixels_checked),
      .lines_started  (lines_started),
      .line_ends      (line_ends)
   );

   always #2 clock = ~clock;

   // Receiver: random backpressure, plus a long hold whenever one is asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_ready <= 1'b0;
         hold_left = LongHold;
         holds_done = holds_done + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic req_payload_type start_item(input int xs, input int ys,
                                                  input int xe, input int ye,
                                                  input color_type c);
      req_payload_type it;
      it.cmd = CmdStart;
      it.x_start = coord_type'(xs);
      it.y_start = coord_type'(ys);
      it.x_end = coord_type'(xe);
      it.y_end = coord_type'(ye);
      it.color_in = c;
      return it;
   endfunction

   // Step item; the other fields carry junk the block must ignore
   function automatic req_payload_type step_item();
      req_payload_type it;
      it.cmd = CmdStep;
      it.x_start = coord_type'($urandom);
      it.y_start = coord_type'($urandom);
      it.x_end = coord_type'($urandom);
      it.y_end = coord_type'($urandom);
      it.color_in = $urandom;
      return it;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic int pick_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return -2048;
      if (roll < 20)
         return 2047;
      return rand_coord();
   endfunction

   // Offer one item, holding it until the block takes it
   task automatic offer(input req_payload_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Start a line and follow it with a number of steps; steps past the end are idle
   task automatic trace_line(input int xs, input int ys, input int xe, input int ye,
                             input color_type c, input int steps);
      int adx, ady, span;
      adx = (xe > xs) ? xe - xs : xs - xe;
      ady = (ye > ys) ? ye - ys : ys - ye;
      span = (adx > ady) ? adx : ady;
      offer(start_item(xs, ys, xe, ye, c));
      pixel_items++;
      for (int i = 0; i < steps; i++) begin
         offer(step_item());
         if (i < span)
            pixel_items++;
      end
   endtask

   // One random line: mostly short and complete, some abandoned or overstepped
   task automatic random_line();
      int kind, reach, off, xs, ys, xe, ye, adx, ady, span, steps, roll;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         // Noise: endpoints anywhere, abandoned after a few steps
         xs = rand_coord();
         ys = rand_coord();
         xe = rand_coord();
         ye = rand_coord();
         steps = $urandom_range(0, 3);
      end else begin
         reach = (kind < 94) ? 15 : 200;
         xs = pick_coord();
         ys = pick_coord();
         off = int'($urandom_range(0, 2 * reach)) - reach;
         xe = xs + off;
         if (xe > 2047 || xe < -2048)
            xe = xs - off;
         off = int'($urandom_range(0, 2 * reach)) - reach;
         ye = ys + off;
         if (ye > 2047 || ye < -2048)
            ye = ys - off;
         adx = (xe > xs) ? xe - xs : xs - xe;
         ady = (ye > ys) ? ye - ys : ys - ye;
         span = (adx > ady) ? adx : ady;
         roll = $urandom_range(0, 99);
         if (roll < 85)
            steps = span;
         else if (roll < 93)
            steps = span + $urandom_range(1, 3);
         else
            steps = $urandom_range(0, span);
      end
      trace_line(xs, ys, xe, ye, $urandom, steps);
   endtask

   // Stimulus and verdict
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: step while idle, single-pixel line, extreme diagonals, edge lines
      offer(step_item());
      trace_line(0, 0, 0, 0, 32'h0000_0000, 1);
      trace_line(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF, 2);
      trace_line(2047, 2047, -2048, -2048, 32'hA5A5_5A5A, 2);
      trace_line(2047, -2048, -2048, 2047, 32'h5A5A_A5A5, 1);
      trace_line(-2048, 2047, -2048, 2044, 32'h0000_00FF, 3);
      trace_line(10, -3, 4, -1, 32'h8000_0001, 6);

      // Random lines in three idling phases; the last one starts with a long hold
      while (pixel_items < ItemTarget) begin
         if (pixel_items >= 2 * ItemTarget / 3 && send_idle_pct != 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            holds_asked = holds_asked + 1;
         end else if (pixel_items >= ItemTarget / 3 && pixel_items < 2 * ItemTarget / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 17;
         end
         random_line();
      end
      req_valid <= 1'b0;

      // Drain, then a few more cycles to catch stray pixels
      @(posedge clock);
      while (pixels_pending != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d line starts and %0d checked pixels, %0d of them line ends.",
               lines_started, pixels_checked, line_ends);
      if (fail_count == 0 && pixels_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
